[rtl/core/cid_pkg.sv]
package cid_pkg;

    localparam int CFG_W      = 8;
    localparam int CODE_W     = 12;
    localparam int CUR_W      = 12;
    localparam int SUM_W      = 21;
    localparam int LEFT_W     = 9;
    localparam int AVG_W      = 12;
    localparam int THR_W      = 13;
    localparam int DL_W       = 14;
    localparam int PROD_W     = 20;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HALF_CH0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_HALF_CH1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PCT_CH0  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PCT_CH1  = 2'd3;

    localparam logic [CFG_W-1:0] CFG_RESET_VAL = 8'd10;

    localparam logic REQ_ARM    = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    // code*721/1000 == (code*CUR_MUL) >> CUR_SHIFT for every 12-bit code
    localparam logic [22:0] CUR_MUL   = 23'd6048187;
    localparam int          CUR_SHIFT = 23;

    // x/100 == (x*PCT_RECIP) >> PCT_SHIFT for x below 2**20
    localparam logic [20:0] PCT_RECIP = 21'd1342178;
    localparam int          PCT_SHIFT = 27;

    localparam logic [DL_W-1:0]  THR_FLOOR = 14'd5;
    localparam logic [DL_W-1:0]  THR_CEIL  = 14'd8191;
    localparam logic [AVG_W-1:0] AVG_CEIL  = 12'd4095;

    localparam int             DIV_STEPS = SUM_W;
    localparam int             DIV_CNT_W = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'(DIV_STEPS - 1);

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    typedef struct packed {
        logic [1:0][CFG_W-1:0] win_half;
        logic [1:0][CFG_W-1:0] max_pct;
    } t_cfg_regs;

    typedef struct packed {
        logic              ch;
        logic [SUM_W-1:0]  sum;
        logic [LEFT_W-1:0] div;
        logic [CFG_W-1:0]  pct;
        logic              all_done;
    } t_job;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_SCALE,
        BK_DONE
    } t_back_state;

endpackage

[rtl/core/cid_front.sv]
module cid_front #(
    parameter int CHANNELS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,   // [11:0] adc_code
    input  logic [1:0]           s_axis_tuser,   // [0] req_type, [1] channel
    input  cid_pkg::t_cfg_regs   i_cfg,
    input  cid_pkg::t_q_status   i_q_status,
    output logic                 o_push,
    output cid_pkg::t_job        o_push_job
);

    logic                            r_a_valid;
    logic                            r_a_req;
    logic                            r_a_ch;
    logic [cid_pkg::CUR_W-1:0]       r_a_cur;
    logic [1:0][cid_pkg::LEFT_W-1:0] r_left;
    logic [1:0][cid_pkg::SUM_W-1:0]  r_sum;

    logic [34:0]                     w_cur_prod;
    logic                            w_accept;
    logic [cid_pkg::LEFT_W-1:0]      w_left_sel;
    logic [cid_pkg::LEFT_W-1:0]      w_left_dec;
    logic [cid_pkg::SUM_W-1:0]       w_sum_new;
    logic                            w_take;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_cur_prod = 35'(s_axis_tdata[cid_pkg::CODE_W-1:0]) * 35'(cid_pkg::CUR_MUL);

    // one free queue slot for every item that may still push
    assign s_axis_tready = ({1'b0, i_q_status.count} + {{cid_pkg::QCNT_W{1'b0}}, r_a_valid})
                           < (cid_pkg::QCNT_W+1)'(cid_pkg::QDEPTH);

    assign w_left_sel = r_left[r_a_ch];
    assign w_left_dec = w_left_sel - 1'b1;
    assign w_sum_new  = r_sum[r_a_ch] + cid_pkg::SUM_W'(r_a_cur);
    assign w_take     = r_a_valid && (r_a_req == cid_pkg::REQ_SAMPLE) && (w_left_sel != '0);

    assign o_push              = w_take && (w_left_dec == '0);
    assign o_push_job.ch       = r_a_ch;
    assign o_push_job.sum      = w_sum_new;
    assign o_push_job.div      = {i_cfg.win_half[r_a_ch], 1'b0};
    assign o_push_job.pct      = i_cfg.max_pct[r_a_ch];
    assign o_push_job.all_done = (r_left[~r_a_ch] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_req <= s_axis_tuser[0];
            r_a_ch  <= s_axis_tuser[1];
            r_a_cur <= w_cur_prod[34:cid_pkg::CUR_SHIFT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_sum  <= '0;
        end else if (r_a_valid && (r_a_req == cid_pkg::REQ_ARM)) begin
            for (int c = 0; c < 2; c++) begin
                if (c < CHANNELS) begin
                    r_left[c] <= {i_cfg.win_half[c], 1'b0};
                    r_sum[c]  <= '0;
                end
            end
        end else if (w_take) begin
            r_left[r_a_ch] <= w_left_dec;
            r_sum[r_a_ch]  <= w_sum_new;
        end
    end

    a_accept_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_a_valid)
        else $error("accepted beat not staged");

endmodule

[rtl/core/cid_queue.sv]
module cid_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cid_pkg::t_job       i_push_job,
    input  logic                i_pop,
    output cid_pkg::t_job       o_head,
    output cid_pkg::t_q_status  o_status
);

    cid_pkg::t_job                 r_mem [cid_pkg::QDEPTH];
    logic [cid_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [cid_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [cid_pkg::QCNT_W-1:0]    r_count;

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < cid_pkg::QCNT_W'(cid_pkg::QDEPTH)) || i_pop)
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue underflow");

endmodule

[rtl/core/cid_back.sv]
module cid_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cid_pkg::t_job       i_q_head,
    input  cid_pkg::t_q_status  i_q_status,
    output logic                o_pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [31:0]         m_axis_tdata,  // [11:0] average_ma, [24:12] threshold_ma,
                                               // [25] unstable, [26] all_done
    output logic [0:0]          m_axis_tuser   // [0] out_channel
);

    cid_pkg::t_back_state            r_state;
    cid_pkg::t_back_state            n_state;
    cid_pkg::t_job                   r_job;
    logic [cid_pkg::LEFT_W-1:0]      r_rem;
    logic [cid_pkg::SUM_W-1:0]       r_quo;
    logic [cid_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [cid_pkg::PROD_W-1:0]      r_prod;
    logic [cid_pkg::DL_W-1:0]        r_dl;
    logic [1:0][cid_pkg::AVG_W-1:0]  r_older;
    logic [1:0][cid_pkg::AVG_W-1:0]  r_newer;
    logic                            r_out_valid;
    logic                            r_out_ch;
    logic [cid_pkg::AVG_W-1:0]       r_out_avg;
    logic [cid_pkg::THR_W-1:0]       r_out_thr;
    logic                            r_out_unst;
    logic                            r_out_done;

    logic [cid_pkg::LEFT_W:0]        w_trial;
    logic                            w_ge;
    logic [cid_pkg::LEFT_W-1:0]      w_rem_next;
    logic [40:0]                     w_scale;
    logic [cid_pkg::AVG_W-1:0]       w_avg;
    logic [cid_pkg::THR_W-1:0]       w_delta;
    logic [cid_pkg::AVG_W-1:0]       w_old;
    logic [cid_pkg::AVG_W-1:0]       w_newer;
    logic                            w_unst;
    logic                            w_out_free;
    logic                            w_load_out;

    assign w_trial    = {r_rem, r_quo[cid_pkg::SUM_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_job.div});
    assign w_rem_next = w_ge ? cid_pkg::LEFT_W'(w_trial - {1'b0, r_job.div})
                             : cid_pkg::LEFT_W'(w_trial);
    assign w_scale    = 41'(r_prod) * 41'(cid_pkg::PCT_RECIP);
    assign w_old      = r_older[r_job.ch];
    assign w_newer    = r_newer[r_job.ch];
    assign w_out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        if (r_job.div == '0) begin
            w_avg = '0;
        end else if (r_quo[cid_pkg::SUM_W-1:cid_pkg::AVG_W] != '0) begin
            w_avg = cid_pkg::AVG_CEIL;
        end else begin
            w_avg = r_quo[cid_pkg::AVG_W-1:0];
        end
    end

    always_comb begin
        if (r_dl < cid_pkg::THR_FLOOR) begin
            w_delta = cid_pkg::THR_W'(cid_pkg::THR_FLOOR);
        end else if (r_dl > cid_pkg::THR_CEIL) begin
            w_delta = cid_pkg::THR_W'(cid_pkg::THR_CEIL);
        end else begin
            w_delta = r_dl[cid_pkg::THR_W-1:0];
        end
    end

    assign w_unst = ({2'b0, w_old} > ({2'b0, w_newer} + {1'b0, w_delta}))
                 && ({2'b0, w_old} > ({2'b0, w_avg} + {1'b0, w_delta}));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cid_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = cid_pkg::BK_DIV;
                end
            end
            cid_pkg::BK_DIV: begin
                if (r_cnt == cid_pkg::DIV_LAST) begin
                    n_state = cid_pkg::BK_MUL;
                end
            end
            cid_pkg::BK_MUL:   n_state = cid_pkg::BK_SCALE;
            cid_pkg::BK_SCALE: n_state = cid_pkg::BK_DONE;
            cid_pkg::BK_DONE: begin
                if (w_out_free) begin
                    n_state = cid_pkg::BK_IDLE;
                end
            end
            default: n_state = cid_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            cid_pkg::BK_IDLE: o_pop      = !i_q_status.empty;
            cid_pkg::BK_DONE: w_load_out = w_out_free;
            default: begin
                o_pop      = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cid_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_head;
            r_rem <= '0;
            r_quo <= i_q_head.sum;
            r_cnt <= '0;
        end else if (r_state == cid_pkg::BK_DIV) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[cid_pkg::SUM_W-2:0], w_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == cid_pkg::BK_MUL) begin
            r_prod <= cid_pkg::PROD_W'(w_old) * cid_pkg::PROD_W'(r_job.pct);
        end
        if (r_state == cid_pkg::BK_SCALE) begin
            r_dl <= w_scale[cid_pkg::PCT_SHIFT +: cid_pkg::DL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older <= '0;
            r_newer <= '0;
        end else if (w_load_out) begin
            r_older[r_job.ch] <= w_newer;
            r_newer[r_job.ch] <= w_avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_ch   <= r_job.ch;
            r_out_avg  <= w_avg;
            r_out_thr  <= w_delta;
            r_out_unst <= w_unst;
            r_out_done <= r_job.all_done;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_done, r_out_unst, r_out_thr, r_out_avg};
    assign m_axis_tuser  = r_out_ch;

    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cid_pkg::BK_DIV) |-> (r_cnt <= cid_pkg::DIV_LAST))
        else $error("divider step count out of range");

    a_pop_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == cid_pkg::BK_DIV))
        else $error("popped job did not start division");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == cid_pkg::BK_DONE))
        else $error("result raised outside completion");

endmodule

[rtl/core/current_instability_detector.sv]
// Channel   | Dir | Handshake                      | Payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata: adc_code; tuser: req_type, channel
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: average, threshold, flags; tuser: channel
// cfg       | in  | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// An arm or a sample that does not close a window only updates the front end and pushes no job.
// A closing sample holds the back end for its pop, 21 bit-serial divide steps,
// threshold multiply, scale and output load, in that order.
// Input stalls when the queued jobs plus the staged beat fill the four-entry job queue.
// Output holds in its own register; the back end waits only when that register is full.
// Reset is synchronous active low; all window state and history clear at once.
module current_instability_detector #(
    parameter int CHANNELS = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [11:0] adc_code
    input  logic [1:0]                        s_axis_tuser,  // [0] req_type, [1] channel
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,  // [11:0] average_ma,
                                                             // [24:12] threshold_ma,
                                                             // [25] unstable, [26] all_done
    output logic [0:0]                        m_axis_tuser,  // [0] out_channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cid_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cid_pkg::CFG_W-1:0]         i_cfg_data
);

    cid_pkg::t_cfg_regs  r_cfg;
    cid_pkg::t_q_status  w_q_status;
    cid_pkg::t_job       w_push_job;
    cid_pkg::t_job       w_q_head;
    logic                w_push;
    logic                w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_half <= {2{cid_pkg::CFG_RESET_VAL}};
            r_cfg.max_pct  <= {2{cid_pkg::CFG_RESET_VAL}};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cid_pkg::CFG_WIN_HALF_CH0: r_cfg.win_half[0] <= i_cfg_data;
                cid_pkg::CFG_WIN_HALF_CH1: r_cfg.win_half[1] <= i_cfg_data;
                cid_pkg::CFG_MAX_PCT_CH0:  r_cfg.max_pct[0]  <= i_cfg_data;
                cid_pkg::CFG_MAX_PCT_CH1:  r_cfg.max_pct[1]  <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    cid_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_cfg         (r_cfg),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_push_job    (w_push_job)
    );

    cid_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .i_pop      (w_pop),
        .o_head     (w_q_head),
        .o_status   (w_q_status)
    );

    cid_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_head      (w_q_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
